FILE: design/assert_macros.svh
// assertion macros shared by the binomial pyramid reduce rtl
// clocked on clk_i and disabled while rst_ni is low, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the module clock
`define ASSERT_CLKRST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication check
`define ASSERT_IMPLY(label, pre, post, msg) \
  `ASSERT_CLKRST(label, (pre) |-> (post), msg)

`endif

FILE: design/bpr_pkg.sv
// shared types, constants and rounding function for the binomial pyramid reduce block
// no dependencies
package bpr_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int PIX_W          = 8;
  localparam int CFG_W          = 13;
  localparam int HSUM_W         = 10;   // horizontal 1-2-1 sum, at most 1020
  localparam int VSUM_W         = 12;   // full 16-weight sum, at most 4080
  localparam int REG_IDX_W      = 1;
  localparam int MIN_SIZE       = 2;
  localparam int FRAC_W         = 4;    // divide by 16

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // one parent pixel after horizontal filtering and position decode
  typedef struct packed {
    logic              acc;      // a horizontal centre completes, line store is touched
    logic              emit;     // a child pixel comes out
    logic              last;     // final child pixel of the frame
    logic              row_one;  // second parent row, top border duplicated
    logic [HSUM_W-1:0] hsum;
  } hitem_t;

  // one line store entry: row before last (upper) and last row (mid)
  typedef struct packed {
    logic [HSUM_W-1:0] upper;
    logic [HSUM_W-1:0] mid;
  } line_word_t;

  // divide by 16, round half to even, limit to 255
  function automatic logic [PIX_W-1:0] round_div16(logic [VSUM_W-1:0] s);
    logic [PIX_W-1:0]  q;
    logic [FRAC_W-1:0] rem;
    logic              up;
    q   = s[VSUM_W-1:FRAC_W];
    rem = s[FRAC_W-1:0];
    up  = (rem > 4'd8) || ((rem == 4'd8) && q[0]);
    if (up && (q != {PIX_W{1'b1}})) begin
      q = q + 1'b1;
    end
    return q;
  endfunction

endpackage

FILE: design/bpr_pix_if.sv
// parent pixel stream interface, valid/ready handshake
// payload widths from bpr_pkg
interface bpr_pix_if;
  import bpr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

FILE: design/bpr_red_if.sv
// reduced (child) pixel stream interface, valid/ready handshake
// payload widths from bpr_pkg
interface bpr_red_if;
  import bpr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] reduced_pixel;
  logic             frame_last;

  modport source (output valid, output reduced_pixel, output frame_last, input ready);
  modport sink   (input valid, input reduced_pixel, input frame_last, output ready);
endinterface

FILE: design/bpr_line_mem.sv
// line store: one write port and one registered read port
// word type from bpr_pkg
module bpr_line_mem #(
  parameter int DEPTH = bpr_pkg::DEF_MAX_WIDTH / 2
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr_i,
  output bpr_pkg::line_word_t         rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr_i,
  input  bpr_pkg::line_word_t         wr_data_i
);
  import bpr_pkg::*;

  line_word_t mem [DEPTH];
  line_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: design/bpr_hfilt.sv
// position tracking and horizontal 1-2-1 filter for the parent pixel stream
// uses bpr_pkg types; produces the line store address for each transaction
module bpr_hfilt #(
  parameter int MAX_WIDTH  = bpr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [bpr_pkg::PIX_W-1:0]        pixel_value_i,
  input  logic                             frame_start_i,
  input  logic [bpr_pkg::CFG_W-1:0]        frame_width_i,
  input  logic [bpr_pkg::CFG_W-1:0]        frame_height_i,
  output bpr_pkg::hitem_t                  item_o,
  output logic [$clog2(MAX_WIDTH/2)-1:0]   addr_o
);
  import bpr_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH / 2);
  localparam int SW0 = (CFG_W > WW) ? CFG_W : WW;
  localparam int SW  = (SW0 > HW) ? SW0 : HW;

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [PIX_W-1:0] prev_q, older_q;

  logic [SW-1:0]     wreg, hreg, w_full, h_full;
  logic [WW-1:0]     w, wm1;
  logic [HW-1:0]     h, hm1;
  logic [CW-1:0]     c, cm1;
  logic [RW-1:0]     r;
  logic [PIX_W-1:0]  left;
  logic              row_end;

  // size registers limited to 2..MAX
  always_comb begin
    wreg   = SW'(frame_width_i);
    hreg   = SW'(frame_height_i);
    w_full = (wreg < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
             (wreg > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : wreg;
    h_full = (hreg < SW'(MIN_SIZE)) ? SW'(MIN_SIZE) :
             (hreg > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : hreg;
    w      = w_full[WW-1:0];
    h      = h_full[HW-1:0];
    wm1    = w - 1'b1;
    hm1    = h - 1'b1;
  end

  always_comb begin
    c    = frame_start_i ? '0 : col_q;
    r    = frame_start_i ? '0 : row_q;
    cm1  = c - 1'b1;
    left = (c == CW'(1)) ? prev_q : older_q;

    item_o.acc     = (c != '0) && (c[0] ^ w[0]);
    item_o.emit    = item_o.acc && (r != '0) && (r[0] ^ h[0]);
    item_o.row_one = (r == RW'(1));
    item_o.last    = (HW'(r) == hm1) && (WW'(c) == wm1);
    item_o.hsum    = HSUM_W'(left) + {1'b0, prev_q, 1'b0} + HSUM_W'(pixel_value_i);
    addr_o         = AW'(cm1 >> 1);
  end

  // next position, wraps at end of row and end of frame
  always_comb begin
    row_end = (WW'(c) >= wm1);
    if (row_end) begin
      col_d = '0;
      row_d = (HW'(r) >= hm1) ? '0 : r + 1'b1;
    end else begin
      col_d = c + 1'b1;
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
      older_q <= '0;
    end else if (acc_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      prev_q  <= pixel_value_i;
      older_q <= prev_q;
    end
  end

endmodule

FILE: design/bpr_vfilt.sv
// vertical 1-2-1 filter stage: line store read-modify-write, rounding and output register
// uses bpr_pkg types and assert_macros.svh
`include "assert_macros.svh"

module bpr_vfilt #(
  parameter int MAX_WIDTH = bpr_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  bpr_pkg::hitem_t                  item_i,
  input  logic [$clog2(MAX_WIDTH/2)-1:0]   addr_i,
  input  bpr_pkg::line_word_t              rd_data_i,
  output logic                             ready_o,
  output logic                             wr_en_o,
  output logic [$clog2(MAX_WIDTH/2)-1:0]   wr_addr_o,
  output bpr_pkg::line_word_t              wr_data_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bpr_pkg::PIX_W-1:0]        reduced_pixel_o,
  output logic                             frame_last_o
);
  import bpr_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH / 2);

  logic        s1_valid_q;
  hitem_t      item_q;
  logic [AW-1:0] addr_q;
  logic        fwd_q;
  line_word_t  fwd_data_q;
  logic        out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic        out_last_q;

  line_word_t        word;
  logic [HSUM_W-1:0] up;
  logic [VSUM_W-1:0] vsum;
  logic              s1_adv;

  always_comb begin
    word   = fwd_q ? fwd_data_q : rd_data_i;
    up     = item_q.row_one ? word.mid : word.upper;
    vsum   = VSUM_W'(up) + VSUM_W'({word.mid, 1'b0}) + VSUM_W'(item_q.hsum);
    s1_adv = s1_valid_q && (!item_q.emit || !out_valid_q || out_ready_i);
    ready_o = !s1_valid_q || s1_adv;

    wr_en_o         = s1_adv && item_q.acc;
    wr_addr_o       = addr_q;
    wr_data_o.upper = word.mid;
    wr_data_o.mid   = item_q.hsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (acc_i) begin
      s1_valid_q <= 1'b1;
      // entry written this cycle is read by the new transaction
      fwd_q      <= item_i.acc && wr_en_o && (addr_i == addr_q);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      item_q     <= item_i;
      addr_q     <= addr_i;
      fwd_data_q <= wr_data_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && item_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && item_q.emit) begin
      out_pix_q  <= round_div16(vsum);
      out_last_q <= item_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reduced_pixel_o = out_pix_q;
  assign frame_last_o    = out_last_q;

  `ASSERT_IMPLY(a_no_accept_on_stall, s1_valid_q && !s1_adv, !acc_i, "accept while stage stalled")
  `ASSERT_IMPLY(a_fwd_needs_access, fwd_q, s1_valid_q && item_q.acc, "forward without store access")
  `ASSERT_IMPLY(a_out_from_stage, $rose(out_valid_q), $past(s1_valid_q && item_q.emit), "output without source")

endmodule

FILE: design/binomial_pyramid_reduce_unit.sv
// top level of the binomial pyramid reduce block: config registers and stage wiring
// uses bpr_pkg, bpr_pix_if, bpr_red_if, bpr_hfilt, bpr_line_mem, bpr_vfilt
//
// usage
// - pix_i carries parent pixels in raster order; frame_start marks pixel (0,0)
// - red_o carries the half-size child image in raster order; frame_last marks
//   the final child pixel of a frame
// - cfg port: cfg_we_i writes cfg_wdata_i into frame_width or frame_height,
//   picked by cfg_idx_i; write only while no transaction is in flight
// - each accepted pixel gives zero or one child pixel
// throughput and pipeline
// - one pixel per cycle sustained unless red_o stalls; the single line store read and
//   write per pixel set that figure (read on accept, write as the pixel stage advances)
// - a child pixel passes the pixel stage and output registers before red_o.valid
// reset
// - position and pixel history clear, sizes return to 4096 x 4096
// - the line store is not cleared; every entry is written before its value is used
// stall
// - a stalled output holds its register; the pixel stage behind it stops and
//   pix_i.ready drops only when that stage holds a pending child pixel
module binomial_pyramid_reduce_unit #(
  parameter int MAX_WIDTH  = bpr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  bpr_pkg::reg_idx_e          cfg_idx_i,
  input  logic [bpr_pkg::CFG_W-1:0]  cfg_wdata_i,
  bpr_pix_if.sink                    pix_i,
  bpr_red_if.source                  red_o
);
  import bpr_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(DEF_MAX_WIDTH);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(DEF_MAX_HEIGHT);

  // size registers
  logic [CFG_W-1:0] frame_width_q, frame_height_q;

  // stage wiring
  logic       acc;
  logic       ready;
  hitem_t     item;
  logic [AW-1:0] rd_addr;
  line_word_t rd_data;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  line_word_t wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_WIDTH;
      frame_height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a pixel transaction completes on valid and ready
  assign acc         = pix_i.valid && ready;
  assign pix_i.ready = ready;

  // position decode and horizontal filter
  bpr_hfilt #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hfilt (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .pixel_value_i  (pix_i.pixel_value),
    .frame_start_i  (pix_i.frame_start),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .item_o         (item),
    .addr_o         (rd_addr)
  );

  // horizontal sums of the last two parent rows, one entry per child column
  bpr_line_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc && item.acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // vertical filter, store update and output register
  bpr_vfilt #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_vfilt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .item_i          (item),
    .addr_i          (rd_addr),
    .rd_data_i       (rd_data),
    .ready_o         (ready),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .out_valid_o     (red_o.valid),
    .out_ready_i     (red_o.ready),
    .reduced_pixel_o (red_o.reduced_pixel),
    .frame_last_o    (red_o.frame_last)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for binomial_pyramid_reduce_unit, one 2x pyramid level
// uses bpr_pkg, bpr_pix_if and bpr_red_if; predicts child pixels in-line
module testbench;
  import bpr_pkg::*;

  localparam int unsigned COORD_W      = 12;
  localparam int unsigned HSUM_DEPTH   = DEF_MAX_WIDTH / 2;
  localparam int unsigned LONG_HOLD    = 120;   // cycles of output back-pressure
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 4;     // stage and output registers plus margin

  typedef enum int {
    PX_RANDOM,
    PX_WHITE,
    PX_BLACK,
    PX_SMOOTH
  } px_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             start;
  } parent_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             is_last;
  } child_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  reg_idx_e         cfg_idx_i   = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  bpr_pix_if pix_if ();
  bpr_red_if red_if ();

  binomial_pyramid_reduce_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .red_o       (red_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: sizes as written, raster position, pixel history, line sums
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  logic [PIX_W-1:0]   prev_px;
  logic [PIX_W-1:0]   older_px;
  logic [HSUM_W-1:0]  hsum_last_row   [HSUM_DEPTH];
  logic [HSUM_W-1:0]  hsum_row_before [HSUM_DEPTH];

  child_t      child_due_q [$];   // child pixels predicted but not yet seen
  parent_t     parent_q    [$];   // parent pixels waiting for the driver
  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned failures       = 0;

  // handshake pacing
  logic        pix_fired    = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned sink_stall   = 0;
  bit          src_calm     = 1'b0;
  bit          sink_calm    = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_served  = 1'b0;

  // register value as the block uses it
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v < MIN_SIZE) begin
      return MIN_SIZE;
    end
    if (v > top) begin
      return top;
    end
    return v;
  endfunction

  // 16-weight sum down to a pixel, ties go to the even value
  function automatic logic [PIX_W-1:0] div16_round_even(input int unsigned total);
    int unsigned q;
    int unsigned frac;
    q    = total >> 4;
    frac = total & 15;
    if (frac > 8 || (frac == 8 && q[0])) begin
      q++;
    end
    if (q > 255) begin
      q = 255;
    end
    return PIX_W'(q);
  endfunction

  // one accepted parent pixel through the 1-2-1 x 1-2-1 reduction
  task automatic reduce_parent(input logic [PIX_W-1:0] px, input logic first);
    int unsigned w, h, c, r, k, left, hsum, mid, up;
    child_t      due;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (first) begin
      col_pos = '0;
      row_pos = '0;
    end
    c = col_pos;
    r = row_pos;
    // a horizontal centre completes when the pixel right of it arrives;
    // on even sizes the centre at column 0 sees its border pixel twice
    if (c >= 1 && ((c + w) % 2 == 1)) begin
      left = (c == 1) ? prev_px : older_px;
      hsum = left + 2 * prev_px + px;
      k    = (c - 1) / 2;
      mid  = hsum_last_row[k];
      // second parent row duplicates the top border
      up   = (r == 1) ? mid : hsum_row_before[k];
      if (r >= 1 && ((r + h) % 2 == 1)) begin
        due.value   = div16_round_even(up + 2 * mid + hsum);
        due.is_last = (r == h - 1) && (c == w - 1);
        child_due_q = {child_due_q, due};
      end
      hsum_row_before[k] = HSUM_W'(mid);
      hsum_last_row[k]   = HSUM_W'(hsum);
    end
    older_px = prev_px;
    prev_px  = px;
    // end of row also when the column sits past a shrunk width
    if (c >= w - 1) begin
      col_pos = '0;
      row_pos = (r >= h - 1) ? '0 : COORD_W'(r + 1);
    end else begin
      col_pos = COORD_W'(c + 1);
    end
  endtask

  function automatic void log_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  task automatic check_child(input child_t got);
    child_t want;
    if (child_due_q.size() == 0) begin
      log_failure($sformatf("child pixel %0d frame_last %0b with none expected",
                            got.value, got.is_last));
    end else begin
      want = child_due_q.pop_front();
      if (got.value !== want.value) begin
        log_failure($sformatf("reduced_pixel expected %0d got %0d", want.value, got.value));
      end
      if (got.is_last !== want.is_last) begin
        log_failure($sformatf("frame_last expected %0b got %0b (pixel %0d)",
                              want.is_last, got.is_last, got.value));
      end
    end
  endtask

  // most gaps short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // observer: config writes, accepted parent transactions, child transactions
  always @(posedge clk_i) begin : observer
    child_t seen;
    if (!rst_ni) begin
      pix_fired  <= 1'b0;
      width_reg  = CFG_W'(DEF_MAX_WIDTH);
      height_reg = CFG_W'(DEF_MAX_HEIGHT);
      col_pos    = '0;
      row_pos    = '0;
      prev_px    = '0;
      older_px   = '0;
      for (int i = 0; i < HSUM_DEPTH; i++) begin
        hsum_last_row[i]   = '0;
        hsum_row_before[i] = '0;
      end
    end else begin
      pix_fired <= pix_if.valid && pix_if.ready;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH:  width_reg  = cfg_wdata_i;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata_i;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        reduce_parent(pix_if.pixel_value, pix_if.frame_start);
        accepted_total++;
      end
      if (red_if.valid && red_if.ready) begin
        seen.value   = red_if.reduced_pixel;
        seen.is_last = red_if.frame_last;
        check_child(seen);
      end
    end
  end

  // parent driver: holds a transaction until it is taken, then may idle a while
  always @(negedge clk_i) begin : pixel_driver
    parent_t nxt;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_fired) begin
      if (src_gap != 0) begin
        src_gap--;
        pix_if.valid <= 1'b0;
      end else if (parent_q.size() != 0) begin
        nxt = parent_q.pop_front();
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= nxt.value;
        pix_if.frame_start <= nxt.start;
        // occasional stretches of back-to-back transactions
        if ($urandom_range(0, 299) == 0) begin
          src_calm = !src_calm;
        end
        src_gap = src_calm ? 0 : pick_gap();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // child sink: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin : child_sink
    if (!rst_ni) begin
      red_if.ready <= 1'b0;
    end else begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        sink_stall  = LONG_HOLD;
      end
      if (sink_stall != 0) begin
        sink_stall--;
        red_if.ready <= 1'b0;
      end else begin
        red_if.ready <= 1'b1;
        if ($urandom_range(0, 499) == 0) begin
          sink_calm = !sink_calm;
        end
        if (!sink_calm && $urandom_range(0, 5) == 0) begin
          sink_sta_update: sink_stall = pick_gap();
        end
      end
    end
  end

  function automatic void queue_pixel(input logic [PIX_W-1:0] value, input logic start);
    parent_t item;
    item.value = value;
    item.start = start;
    parent_q = {parent_q, item};
    queued_total++;
  endfunction

  function automatic void queue_frame(input int unsigned count, input bit with_start,
                                      input px_mode_e mode);
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] value;
    base = PIX_W'($urandom_range(0, 248));
    for (int unsigned i = 0; i < count; i++) begin
      case (mode)
        PX_WHITE:  value = '1;
        PX_BLACK:  value = '0;
        PX_SMOOTH: value = base + PIX_W'($urandom_range(0, 7));
        default:   value = PIX_W'($urandom_range(0, 255));
      endcase
      queue_pixel(value, with_start && (i == 0));
    end
  endfunction

  // wait until every parent transaction is taken and every child pixel seen
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (accepted_total != queued_total || child_due_q.size() != 0);
    // trailing pixels that make no child may still be in the pipe
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // sizes change only with the block idle; ends on a rising edge so that
  // queue pushes never share a time step with the driver
  task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(posedge clk_i);
  endtask

  // register value: mostly small frames, sometimes below the minimum or larger
  function automatic logic [CFG_W-1:0] draw_dim(input int unsigned typical_max,
                                                input int unsigned rare_max);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return CFG_W'($urandom_range(0, 1));
    end
    if (pick == 1) begin
      return CFG_W'($urandom_range(typical_max + 1, rare_max));
    end
    return CFG_W'($urandom_range(2, typical_max));
  endfunction

  initial begin : stimulus
    int unsigned random_base;
    int unsigned w, h, p, new_w, new_h, count;
    px_mode_e    mode;
    bit          at_origin;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.frame_start = 1'b0;
    red_if.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // odd sizes, full-scale pixels: centre at (1,1), sum exactly 16 * 255
    set_frame_size(3, 3);
    queue_frame(9, 1'b1, PX_WHITE);

    // even sizes with border duplication at index 0
    set_frame_size(2, 2);
    // 16-weight sum 24: tie, rounds up to the even value
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd8, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd0, 1'b0);
    // frame end without frame_start wraps; sum 40: tie, stays even
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd8, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd16, 1'b0);
    queue_frame(4, 1'b1, PX_WHITE);
    queue_frame(4, 1'b1, PX_BLACK);

    // height register below the minimum: frame wraps after two rows
    set_frame_size(CFG_W'(4), CFG_W'(1));
    queue_frame(16, 1'b1, PX_RANDOM);
    // width register zero, height above the maximum: row parity of a 4096-row frame
    set_frame_size(CFG_W'(0), CFG_W'(8191));
    queue_frame(64, 1'b1, PX_RANDOM);

    random_base = queued_total;

    // long output hold-off while parent transactions keep coming
    set_frame_size(16, 12);
    hold_request = 1'b1;
    queue_frame(16 * 12, 1'b1, PX_RANDOM);
    queue_frame(16 * 12, 1'b0, PX_SMOOTH);
    queue_frame(16 * 12, 1'b0, PX_RANDOM);

    while (queued_total - random_base < RANDOM_ITEMS) begin
      w = draw_dim(20, 48);
      h = draw_dim(10, 24);
      set_frame_size(CFG_W'(w), CFG_W'(h));
      w = clamp_dim(CFG_W'(w), DEF_MAX_WIDTH);
      h = clamp_dim(CFG_W'(h), DEF_MAX_HEIGHT);
      at_origin = 1'b0;
      mode = ($urandom_range(0, 4) < 3) ? PX_RANDOM : px_mode_e'($urandom_range(1, 3));
      if (w >= 6 && h >= 4 && $urandom_range(0, 5) == 0) begin
        // shrink mid-frame on the third row: the column lands at or past the
        // new row end and the row at or past the new last row, so the frame wraps;
        // two full rows before keep every line sum in use written
        p = $urandom_range(2, w - 1);
        queue_frame(2 * w + p, 1'b1, mode);
        new_w = $urandom_range(2, p + 1);
        new_h = $urandom_range(2, 3);
        set_frame_size(CFG_W'(new_w), CFG_W'(new_h));
        queue_frame(2 * new_w * new_h + $urandom_range(0, 5), 1'b0, mode);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          mode = ($urandom_range(0, 4) < 3) ? PX_RANDOM : px_mode_e'($urandom_range(1, 3));
          if ($urandom_range(0, 4) == 0) begin
            // broken frame, cut short by the next frame_start
            count = $urandom_range(1, w * h - 1);
            queue_frame(count, 1'b1, mode);
            at_origin = 1'b0;
          end else begin
            // back-to-back frames may rely on the wrap alone
            queue_frame(w * h, !(at_origin && $urandom_range(0, 1) == 1), mode);
            at_origin = 1'b1;
          end
        end
      end
    end

    settle();
    if (child_due_q.size() != 0) begin
      log_failure($sformatf("%0d child pixels never arrived", child_due_q.size()));
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
